[design/cat_pkg.sv]
// ----------------------------------------------------------------------------
// cat_pkg: shared codes and types for the client address table
// Operation and status codes, result selectors and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cat_pkg;

    // Operation codes carried in the request
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        RES_CREATE,
        RES_HIT,
        RES_MISS,
        RES_FULL,
        RES_BAD,
        RES_REMOVE,
        RES_NONE
    } res_sel_t;

    typedef struct packed {
        logic     load;      // latch the request and set the scan pointer
        logic     scan;      // read the next entry below the count
        logic     shift;     // remove in progress: capture or move entries down
        logic     search;    // step the free-id pointer
        logic     res_load;  // commit the operation and load the result
        res_sel_t sel;
    } cat_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       full;
        logic       slot_bad;
        logic       id_free;
        logic       hit;
        logic       exhausted;
        logic       out_free;
    } cat_sts_t;

endpackage

[design/cat_datapath.sv]
// ----------------------------------------------------------------------------
// cat_datapath: entry memory, scan pointer, id bitmap and result register
// Executes the commands of the controller and reports scan and search status.
// ----------------------------------------------------------------------------
module cat_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cat_pkg::cat_cmd_t cmd,
    output cat_pkg::cat_sts_t sts,
    input  logic [1:0]        req_mode,
    input  logic [31:0]       req_ip_addr,
    input  logic [15:0]       req_port_num,
    input  logic [3:0]        req_slot_position,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [1:0]        res_status,
    output logic [4:0]        res_client_id,
    output logic [3:0]        res_match_position,
    output logic [4:0]        res_entry_count
);
    import cat_pkg::*;

    localparam int PW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (CW > 4) ? CW : 4;

    typedef struct packed {
        logic [31:0]   ip;
        logic [15:0]   port;
        logic [CW-1:0] id;
    } entry_t;

    entry_t mem [TABLE_DEPTH];

    logic [1:0]             mode_reg;
    logic [31:0]            ip_reg;
    logic [15:0]            port_reg;
    logic [3:0]             slot_reg;
    logic [CW-1:0]          ptr_reg;
    logic                   live_reg;
    logic [PW-1:0]          rd_idx_reg;
    entry_t                 rdata_reg;
    logic [CW-1:0]          rm_id_reg;
    logic [CW-1:0]          cnt_reg;
    logic [TABLE_DEPTH-1:0] used_reg;
    logic                   m_tvalid_reg;
    logic [1:0]             status_reg;
    logic [4:0]             id_reg;
    logic [3:0]             pos_reg;
    logic [4:0]             count_reg;

    logic [SW-1:0] slot_ext;
    logic [PW-1:0] slot_idx;
    logic          full;
    logic          ptr_in_range;
    logic          out_free;
    logic          capture;
    logic [CW-1:0] new_id;
    logic [CW-1:0] rm_id_m1;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    entry_t        wr_data;
    logic [1:0]    res_st;
    logic [CW-1:0] res_id;
    logic [PW-1:0] res_pos;
    logic [CW-1:0] res_cnt;

    assign slot_ext     = SW'(slot_reg);
    assign slot_idx     = slot_ext[PW-1:0];
    assign full         = (cnt_reg == CW'(TABLE_DEPTH));
    assign ptr_in_range = (ptr_reg < cnt_reg);
    assign out_free     = !m_tvalid_reg || m_tready;
    assign capture      = cmd.shift && live_reg && (rd_idx_reg == slot_idx);
    assign new_id       = ptr_reg + CW'(1);
    assign rm_id_m1     = rdata_reg.id - CW'(1);

    always_comb begin
        sts.mode      = mode_reg;
        sts.full      = full;
        sts.slot_bad  = (slot_ext >= SW'(cnt_reg));
        sts.id_free   = !used_reg[ptr_reg[PW-1:0]];
        sts.hit       = live_reg && (rdata_reg.ip == ip_reg) && (rdata_reg.port == port_reg);
        sts.exhausted = !live_reg && !ptr_in_range;
        sts.out_free  = out_free;
    end

    // Single write port: a create commit or one step of the shift down
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg - PW'(1);
        wr_data = rdata_reg;
        if (cmd.res_load && cmd.sel == RES_CREATE) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg[PW-1:0];
            wr_data = '{ip: ip_reg, port: port_reg, id: new_id};
        end else if (cmd.shift && live_reg && !capture) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan && ptr_in_range) begin
            rdata_reg <= mem[ptr_reg[PW-1:0]];
        end
    end

    always_comb begin
        res_st  = ST_OK;
        res_id  = '0;
        res_pos = '0;
        res_cnt = cnt_reg;
        case (cmd.sel)
            RES_CREATE: begin
                res_id  = new_id;
                res_pos = cnt_reg[PW-1:0];
                res_cnt = cnt_reg + CW'(1);
            end
            RES_HIT: begin
                res_id  = rdata_reg.id;
                res_pos = rd_idx_reg;
            end
            RES_MISS: res_st = ST_NOT_FOUND;
            RES_FULL: res_st = ST_FULL;
            RES_BAD:  res_st = ST_BAD_POS;
            RES_REMOVE: begin
                res_id  = rm_id_reg;
                res_pos = slot_idx;
                res_cnt = cnt_reg - CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            used_reg     <= '0;
            live_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.res_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.res_load) begin
                case (cmd.sel)
                    RES_CREATE: begin
                        cnt_reg                     <= cnt_reg + CW'(1);
                        used_reg[ptr_reg[PW-1:0]]   <= 1'b1;
                    end
                    RES_REMOVE: cnt_reg <= cnt_reg - CW'(1);
                    default: ;
                endcase
            end
            if (capture) begin
                used_reg[rm_id_m1[PW-1:0]] <= 1'b0;
            end
            if (cmd.load) begin
                live_reg <= 1'b0;
            end else if (cmd.scan) begin
                live_reg <= ptr_in_range;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= req_mode;
            ip_reg   <= req_ip_addr;
            port_reg <= req_port_num;
            slot_reg <= req_slot_position;
            ptr_reg  <= (req_mode == MODE_REMOVE) ? CW'(req_slot_position) : '0;
        end else if (cmd.scan && ptr_in_range) begin
            ptr_reg    <= ptr_reg + CW'(1);
            rd_idx_reg <= ptr_reg[PW-1:0];
        end else if (cmd.search) begin
            ptr_reg <= ptr_reg + CW'(1);
        end
        if (capture) begin
            rm_id_reg <= rdata_reg.id;
        end
        if (cmd.res_load) begin
            status_reg <= res_st;
            id_reg     <= 5'(res_id);
            pos_reg    <= 4'(res_pos);
            count_reg  <= 5'(res_cnt);
        end
    end

    assign m_tvalid           = m_tvalid_reg;
    assign res_status         = status_reg;
    assign res_client_id      = id_reg;
    assign res_match_position = pos_reg;
    assign res_entry_count    = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_create_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.res_load && cmd.sel == RES_CREATE) |-> !full)
        else $error("create committed on a full table");

    a_result_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> out_free)
        else $error("result loaded over an untaken result");

    a_ids_match_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> ($countones(used_reg) == int'(cnt_reg)))
        else $error("id bitmap out of step with entry count");

endmodule

[design/cat_ctrl.sv]
// ----------------------------------------------------------------------------
// cat_ctrl: operation sequencer for the client address table
// Takes a request, steps the datapath through search or scan and loads
// the result once the output register is free.
// ----------------------------------------------------------------------------
module cat_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cat_pkg::cat_sts_t sts,
    output cat_pkg::cat_cmd_t cmd
);
    import cat_pkg::*;

    localparam logic [2:0] STATE_IDLE     = 3'd0;
    localparam logic [2:0] STATE_DISPATCH = 3'd1;
    localparam logic [2:0] STATE_SCAN     = 3'd2;
    localparam logic [2:0] STATE_SEARCH   = 3'd3;
    localparam logic [2:0] STATE_WAIT     = 3'd4;

    logic [2:0] state_reg, state_next;
    res_sel_t   sel_reg, sel_next;
    logic       fin;
    res_sel_t   fin_sel;

    always_comb begin
        cmd        = '{default: '0, sel: RES_NONE};
        state_next = state_reg;
        sel_next   = sel_reg;
        fin        = 1'b0;
        fin_sel    = RES_NONE;
        unique case (state_reg)
            STATE_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = STATE_DISPATCH;
                end
            end
            STATE_DISPATCH: begin
                unique case (sts.mode)
                    MODE_CREATE: begin
                        if (sts.full) begin
                            fin     = 1'b1;
                            fin_sel = RES_FULL;
                        end else begin
                            state_next = STATE_SEARCH;
                        end
                    end
                    MODE_LOOKUP: state_next = STATE_SCAN;
                    MODE_REMOVE: begin
                        if (sts.slot_bad) begin
                            fin     = 1'b1;
                            fin_sel = RES_BAD;
                        end else begin
                            state_next = STATE_SCAN;
                        end
                    end
                    default: begin
                        fin     = 1'b1;
                        fin_sel = RES_NONE;
                    end
                endcase
            end
            STATE_SCAN: begin
                cmd.shift = (sts.mode == MODE_REMOVE);
                if (sts.mode == MODE_LOOKUP && sts.hit) begin
                    fin     = 1'b1;
                    fin_sel = RES_HIT;
                end else if (sts.exhausted) begin
                    fin     = 1'b1;
                    fin_sel = (sts.mode == MODE_LOOKUP) ? RES_MISS : RES_REMOVE;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            STATE_SEARCH: begin
                if (sts.id_free) begin
                    fin     = 1'b1;
                    fin_sel = RES_CREATE;
                end else begin
                    cmd.search = 1'b1;
                end
            end
            STATE_WAIT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    cmd.sel      = sel_reg;
                    state_next   = STATE_IDLE;
                end
            end
            default: state_next = STATE_IDLE;
        endcase

        // Commit now if the output register is free, else hold the selector
        if (fin) begin
            if (sts.out_free) begin
                cmd.res_load = 1'b1;
                cmd.sel      = fin_sel;
                state_next   = STATE_IDLE;
            end else begin
                sel_next   = fin_sel;
                state_next = STATE_WAIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_IDLE;
            sel_reg   <= RES_NONE;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign s_tready = (state_reg == STATE_IDLE);

endmodule

[design/client_address_table.sv]
// ----------------------------------------------------------------------------
// client_address_table: endpoint table with lowest-free-id allocation
// Stream front end around the sequencer and the table datapath.
// ----------------------------------------------------------------------------
// The block keeps up to TABLE_DEPTH endpoints (IPv4 address, port, id) in
// positions 0 to count-1 and takes one request at a time. Create appends the
// endpoint at the end of the table with the lowest id from 1 to TABLE_DEPTH
// that is not in use; lookup returns the lowest position whose address and
// port both match; remove deletes a position and moves the later entries
// down. Each request gives exactly one result. A request passes a decode
// step and then its walk: create steps an id pointer over a bitmap, one id
// a cycle, until the first free id; lookup reads the entry memory one
// position a cycle through its registered read port; remove reads from the
// given position to the end of the table and writes each entry one place
// lower. Full, bad-position and unknown-mode requests finish at decode. The
// result register frees the request side: a new request is taken while an
// earlier result still waits on m_tready. The entry memory needs no clearing
// after reset, since only positions below the count are ever read.
// ----------------------------------------------------------------------------
module client_address_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // ip_addr[31:0], port_num[47:32],
                                   // slot_position[51:48], zero pad[55:52]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], client_id[6:2],
                                   // match_position[10:7], entry_count[15:11]
);
    import cat_pkg::*;

    cat_cmd_t   cmd;
    cat_sts_t   sts;
    logic [1:0] res_status;
    logic [4:0] res_client_id;
    logic [3:0] res_match_position;
    logic [4:0] res_entry_count;

    // Sequence each request: decode, then walk the table or the id bitmap
    cat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the entries, the count, the id bitmap and the result register
    cat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .req_mode           (s_tuser),
        .req_ip_addr        (s_tdata[31:0]),
        .req_port_num       (s_tdata[47:32]),
        .req_slot_position  (s_tdata[51:48]),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .res_status         (res_status),
        .res_client_id      (res_client_id),
        .res_match_position (res_match_position),
        .res_entry_count    (res_entry_count)
    );

    // Pack the result fields, lowest field in the lowest bits
    assign m_tdata = {res_entry_count, res_match_position, res_client_id, res_status};

endmodule

[tb/tb_client_address_table.sv]
// ----------------------------------------------------------------------------
// tb_client_address_table: self-checking bench for the client address table
// Drive create, lookup and remove requests into the stream input, predict
// every result from an in-bench copy of the endpoint table and compare each
// result field by field, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_client_address_table;

    import cat_pkg::*;

    localparam int TABLE_DEPTH = 16;
    // Mode 3 has no package code; the block must answer it with an empty ok
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Give up when nothing moves on either channel for this many cycles
    localparam int STALL_LIMIT = 2000;
    // Cycles to keep watching after the last result, for strays
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_REQUESTS = 1120;

    typedef struct {
        logic [1:0] status;
        logic [4:0] client_id;
        logic [3:0] match_position;
        logic [4:0] entry_count;
    } table_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // ip_addr[31:0], port_num[47:32],
                                  // slot_position[51:48], zero pad[55:52]
    logic [1:0]  s_tuser  = '0;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // status[1:0], client_id[6:2],
                                  // match_position[10:7], entry_count[15:11]

    // Bench copy of the table: positions below table_count are valid
    logic [31:0] table_ip   [TABLE_DEPTH];
    logic [15:0] table_port [TABLE_DEPTH];
    logic [4:0]  table_id   [TABLE_DEPTH];
    int          table_count = 0;

    table_result_t pending_results [$];
    int            error_count = 0;
    int            stall_cycles = 0;
    // Suppress idling on both channels while set
    bit            no_idle = 1'b0;

    client_address_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Return the lowest id from 1 up that no valid entry holds, 0 if none
    function automatic logic [4:0] lowest_free_id();
        bit taken;
        for (int id = 1; id <= TABLE_DEPTH; id++) begin
            taken = 1'b0;
            for (int i = 0; i < table_count; i++) begin
                if (table_id[i] == id[4:0]) taken = 1'b1;
            end
            if (!taken) return id[4:0];
        end
        return 5'd0;
    endfunction

    // Apply one request to the bench table and return the result it must give
    function automatic table_result_t apply_table_request(input logic [1:0] mode,
                                                          input logic [31:0] ip,
                                                          input logic [15:0] port,
                                                          input logic [3:0] slot);
        table_result_t r;
        r.status         = ST_OK;
        r.client_id      = '0;
        r.match_position = '0;
        case (mode)
            MODE_CREATE: begin
                if (table_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    r.client_id             = lowest_free_id();
                    r.match_position        = table_count[3:0];
                    table_ip[table_count]   = ip;
                    table_port[table_count] = port;
                    table_id[table_count]   = r.client_id;
                    table_count++;
                end
            end
            MODE_LOOKUP: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < table_count; i++) begin
                    if (r.status == ST_NOT_FOUND && table_ip[i] == ip &&
                        table_port[i] == port) begin
                        r.status         = ST_OK;
                        r.client_id      = table_id[i];
                        r.match_position = i[3:0];
                    end
                end
            end
            MODE_REMOVE: begin
                if (int'(slot) >= table_count) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.client_id      = table_id[slot];
                    r.match_position = slot;
                    // Close the gap: move every later entry one place down
                    for (int i = int'(slot); i + 1 < table_count; i++) begin
                        table_ip[i]   = table_ip[i + 1];
                        table_port[i] = table_port[i + 1];
                        table_id[i]   = table_id[i + 1];
                    end
                    table_count--;
                end
            end
            default: ;
        endcase
        r.entry_count = table_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Present one request at the falling edge, hold it until accepted, then
    // queue its predicted result. Leave tvalid high so back-to-back requests
    // never drop it within one time step.
    task automatic send_request(input logic [1:0] mode, input logic [31:0] ip,
                                input logic [15:0] port, input logic [3:0] slot);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0000, slot, port, ip};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_table_request(mode, ip, port, slot));
    endtask

    // Result side: stall at random unless a quiet stretch is running
    always @(negedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // Check every accepted result against the oldest prediction
    always @(posedge aclk) begin
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, m_tdata", int'(m_tdata), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] != want.status)
                    report_mismatch("status", int'(m_tdata[1:0]), int'(want.status));
                if (m_tdata[6:2] != want.client_id)
                    report_mismatch("client_id", int'(m_tdata[6:2]),
                                    int'(want.client_id));
                if (m_tdata[10:7] != want.match_position)
                    report_mismatch("match_position", int'(m_tdata[10:7]),
                                    int'(want.match_position));
                if (m_tdata[15:11] != want.entry_count)
                    report_mismatch("entry_count", int'(m_tdata[15:11]),
                                    int'(want.entry_count));
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("tb_client_address_table NOT OK");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Create at the all-zero and all-one endpoints, then a duplicate
    task automatic test_create_extremes();
        send_request(MODE_CREATE, 32'h0000_0000, 16'h0000, 4'd0);
        send_request(MODE_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
        send_request(MODE_CREATE, 32'h0000_0000, 16'h0000, 4'd0);
    endtask

    // Hit on the lower of two duplicates, hit on the all-one entry, and misses
    task automatic test_lookup_cases();
        send_request(MODE_LOOKUP, 32'h0000_0000, 16'h0000, 4'd0);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 4'd0);
        send_request(MODE_LOOKUP, 32'h0000_0000, 16'h0001, 4'd0);
        send_request(MODE_LOOKUP, 32'h8000_0000, 16'h0000, 4'd0);
    endtask

    // Refuse positions at or past the count, remove the head, then reuse its id
    task automatic test_remove_cases();
        send_request(MODE_REMOVE, $urandom, 16'($urandom), 4'd15);
        send_request(MODE_REMOVE, $urandom, 16'($urandom), 4'd3);
        send_request(MODE_REMOVE, $urandom, 16'($urandom), 4'd0);
        send_request(MODE_LOOKUP, 32'h0000_0000, 16'h0000, 4'd0);
        send_request(MODE_CREATE, 32'h1234_5678, 16'h9ABC, 4'd0);
    endtask

    task automatic test_unused_mode();
        send_request(MODE_UNUSED, $urandom, 16'($urandom), 4'($urandom));
    endtask

    // Fill to the top, refuse one more, then hit and remove the last position
    task automatic test_full_table();
        while (table_count < TABLE_DEPTH)
            send_request(MODE_CREATE, $urandom, 16'($urandom), 4'($urandom));
        send_request(MODE_CREATE, $urandom, 16'($urandom), 4'($urandom));
        send_request(MODE_LOOKUP, table_ip[TABLE_DEPTH-1], table_port[TABLE_DEPTH-1], 4'd0);
        send_request(MODE_REMOVE, $urandom, 16'($urandom), 4'd15);
    endtask

    // Random traffic that swings the table between empty and full, so ids
    // get freed and reused at every position
    task automatic test_random_traffic();
        bit          filling;
        int          pick;
        int          which;
        logic [31:0] ip;
        logic [15:0] port;
        filling = 1'b1;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            // Hold one long stretch with no idling on either side
            no_idle = (n >= 400 && n < 650);
            if (table_count == TABLE_DEPTH) filling = 1'b0;
            else if (table_count == 0) filling = 1'b1;
            else if ($urandom_range(99) < 3) filling = !filling;
            pick  = $urandom_range(99);
            which = (table_count > 0) ? $urandom_range(table_count - 1) : 0;
            ip    = $urandom;
            port  = 16'($urandom);
            if (pick < (filling ? 50 : 15)) begin
                // Mostly fresh endpoints, some duplicates of live ones
                if (table_count > 0 && $urandom_range(99) < 20) begin
                    ip   = table_ip[which];
                    port = table_port[which];
                end
                send_request(MODE_CREATE, ip, port, 4'($urandom));
            end else if (pick < (filling ? 85 : 50)) begin
                // Mostly hits, then near misses and plain misses
                pick = $urandom_range(99);
                if (table_count > 0 && pick < 70) begin
                    ip   = table_ip[which];
                    port = table_port[which];
                end else if (table_count > 0 && pick < 85) begin
                    ip   = table_ip[which] ^ (32'h1 << $urandom_range(31));
                    port = $urandom_range(1) ? table_port[which] : port;
                end
                send_request(MODE_LOOKUP, ip, port, 4'($urandom));
            end else begin
                // Mostly valid positions, the rest anywhere in range
                if (table_count > 0 && $urandom_range(99) < 85)
                    send_request(MODE_REMOVE, ip, port, which[3:0]);
                else
                    send_request(MODE_REMOVE, ip, port, 4'($urandom_range(15)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_create_extremes();
        test_lookup_cases();
        test_remove_cases();
        test_unused_mode();
        test_full_table();
        test_random_traffic();

        // Drop the request valid, drain the outstanding results, then keep
        // watching for strays before the verdict
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_client_address_table OK");
        end else begin
            $display("tb_client_address_table NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
design/cat_pkg.sv
design/cat_datapath.sv
design/cat_ctrl.sv
design/client_address_table.sv
tb/tb_client_address_table.sv
